/* rtl/ibrd_pkg.sv */
package ibrd_pkg;

  // default fraction bits of the fixed-point results
  localparam int FRAC_BITS_DEF = 16;

  // datapath widths of one scaling lane
  localparam int MAG_W   = 16;
  localparam int NQ_W    = 16;
  localparam int NR_W    = 40;
  localparam int SH_W    = 5;
  localparam int DODD_W  = 19;
  localparam int RECIP_W = 16;
  localparam int RSH_W   = 6;
  localparam int PQ_W    = MAG_W + NQ_W;
  localparam int V_W     = 56;
  localparam int W_W     = 34;
  localparam int QE_W    = 16;
  localparam int QL_W    = QE_W + 1;

  // sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BURST,
    PH_SYNC,
    PH_GYRO
  } phase_t;

  // input item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE_SEL  = 2'd0;
  localparam logic [1:0] CFG_ACC_RANGE = 2'd1;
  localparam logic [1:0] CFG_GYR_RANGE = 2'd2;
  localparam logic [1:0] CFG_RATE_MODE = 2'd3;

  // output rate modes and their filter group delays
  localparam logic [1:0]  RATE_1000 = 2'd1;
  localparam logic [1:0]  RATE_2000 = 2'd2;
  localparam logic [12:0] GD_400    = 13'd7000;
  localparam logic [12:0] GD_1000   = 13'd2500;
  localparam logic [12:0] GD_2000   = 13'd1500;

  // byte positions, accel burst
  localparam logic [4:0] POS_TICK0    = 5'd8;
  localparam logic [4:0] POS_TICK1    = 5'd9;
  localparam logic [4:0] POS_TICK2    = 5'd10;
  localparam logic [4:0] POS_AX_L     = 5'd14;
  localparam logic [4:0] POS_AX_H     = 5'd15;
  localparam logic [4:0] POS_AY_L     = 5'd16;
  localparam logic [4:0] POS_AY_H     = 5'd17;
  localparam logic [4:0] POS_TEMP_MSB = 5'd18;
  localparam logic [4:0] POS_TEMP_LSB = 5'd19;
  // byte positions, sync read
  localparam logic [4:0] POS_AZ_L     = 5'd2;
  localparam logic [4:0] POS_AZ_H     = 5'd3;
  // byte positions, gyro burst
  localparam logic [4:0] POS_GX_L     = 5'd1;
  localparam logic [4:0] POS_GX_H     = 5'd2;
  localparam logic [4:0] POS_GY_L     = 5'd3;
  localparam logic [4:0] POS_GY_H     = 5'd4;
  localparam logic [4:0] POS_GZ_L     = 5'd5;
  localparam logic [4:0] POS_GZ_H     = 5'd6;

  // temperature: raw/8 plus 296.15 kelvin
  localparam longint unsigned TEMP_OFS_CENTI = 29615;
  localparam longint unsigned CENTI          = 100;
  localparam logic [30:0]     TEMP_MAX       = '1;

  // accel scale: raw * 9.80665 * range_g / 2^17, range_g = base * 2^code
  localparam longint unsigned ACC_MUL   = 980665;
  localparam longint unsigned ACC_DEN   = 100000;
  localparam int              ACC_REF   = 17;
  localparam int              ACC_POW2  = 5;
  localparam longint unsigned ACC_ODD   = 3125;
  localparam int              ACC_RSH   = 27;
  localparam longint unsigned ACC_RECIP = (longint'(1) << ACC_RSH) / ACC_ODD;

  // gyro scale: raw * 0.01745329252 / (8.192 * 2^(code+1))
  localparam longint unsigned GYR_MUL   = 1745329252;
  localparam longint unsigned GYR_DEN   = 100000000;
  localparam int              GYR_REF   = 14;
  localparam int              GYR_POW2  = 8;
  localparam longint unsigned GYR_ODD   = 390625;
  localparam int              GYR_RSH   = 34;
  localparam longint unsigned GYR_RECIP = (longint'(1) << GYR_RSH) / GYR_ODD;

  // per-range constants of one lane: q = mag*nq + (mag*nr + half) / den,
  // den = dodd * 2^sh, the second quotient by reciprocal 2^-rsh * recip
  typedef struct packed {
    logic [NQ_W-1:0]    nq;
    logic [NR_W-1:0]    nr;
    logic [NR_W-1:0]    half;
    logic [SH_W-1:0]    sh;
    logic [DODD_W-1:0]  dodd;
    logic [RECIP_W-1:0] recip;
    logic [RSH_W-1:0]   rsh;
  } scale_t;

  // stage load enables of a lane pipeline
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctl_t;

  // accel range table entry, evaluated at elaboration
  function automatic scale_t acc_entry(input int frac, input logic base,
                                       input logic [1:0] code);
    scale_t          e;
    longint unsigned kmul;
    longint unsigned n;
    longint unsigned dg;
    longint unsigned nq;
    int              s;
    int              j;
    kmul = base ? 2 * ACC_MUL : 3 * ACC_MUL;
    s    = int'(code) + frac;
    if (s >= ACC_REF) begin
      n = kmul << (s - ACC_REF);
      j = 0;
    end else begin
      n = kmul;
      j = ACC_REF - s;
    end
    dg      = ACC_DEN << j;
    nq      = (n >> j) / ACC_DEN;
    e.nq    = NQ_W'(nq);
    e.nr    = NR_W'(n - nq * dg);
    e.half  = NR_W'(dg >> 1);
    e.sh    = SH_W'(ACC_POW2 + j);
    e.dodd  = DODD_W'(ACC_ODD);
    e.recip = RECIP_W'(ACC_RECIP);
    e.rsh   = RSH_W'(ACC_RSH);
    return e;
  endfunction

  // gyro range table entry, evaluated at elaboration
  function automatic scale_t gyr_entry(input int frac, input logic [2:0] code);
    scale_t          e;
    longint unsigned n;
    longint unsigned dg;
    longint unsigned nq;
    int              x;
    int              j;
    x = frac - GYR_REF - int'(code);
    if (x >= 0) begin
      n = GYR_MUL << x;
      j = 0;
    end else begin
      n = GYR_MUL;
      j = -x;
    end
    dg      = GYR_DEN << j;
    nq      = (n >> j) / GYR_DEN;
    e.nq    = NQ_W'(nq);
    e.nr    = NR_W'(n - nq * dg);
    e.half  = NR_W'(dg >> 1);
    e.sh    = SH_W'(GYR_POW2 + j);
    e.dodd  = DODD_W'(GYR_ODD);
    e.recip = RECIP_W'(GYR_RECIP);
    e.rsh   = RSH_W'(GYR_RSH);
    return e;
  endfunction

endpackage

/* rtl/ibrd_scale.sv */
module ibrd_scale (
  input  logic                          clk,
  input  ibrd_pkg::lane_ctl_t           ctl,
  input  ibrd_pkg::scale_t              cst,
  input  logic [ibrd_pkg::MAG_W-1:0]    mag,
  input  logic                          neg,
  output logic signed [31:0]            result
);
  import ibrd_pkg::*;

  logic [PQ_W-1:0]      pq1, pq2, pq3;
  logic [V_W-1:0]       v1;
  logic [W_W-1:0]       w2;
  logic [QE_W-1:0]      qe2;
  logic [QL_W-1:0]      ql3;
  logic                 neg1, neg2, neg3;

  logic [V_W-1:0]       v_prod;
  logic [W_W-1:0]       w_sh;
  logic [W_W+RECIP_W-1:0] e_prod;
  logic [W_W-1:0]       q_den;
  logic [W_W-1:0]       rem;
  logic [PQ_W:0]        qsum;

  // stage 1: integer part and remainder numerator
  assign v_prod = V_W'(mag) * V_W'(cst.nr) + V_W'(cst.half);

  // stage 2: drop the power-of-two part, reciprocal estimate of the odd part
  assign w_sh   = W_W'(v1 >> cst.sh);
  assign e_prod = (W_W+RECIP_W)'(w_sh) * (W_W+RECIP_W)'(cst.recip);

  // stage 3: estimate is low by at most one
  assign q_den  = W_W'(qe2) * W_W'(cst.dodd);
  assign rem    = w2 - q_den;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      pq1  <= PQ_W'(mag) * PQ_W'(cst.nq);
      v1   <= v_prod;
      neg1 <= neg;
    end
    if (ctl.en2) begin
      pq2  <= pq1;
      w2   <= w_sh;
      qe2  <= QE_W'(e_prod >> cst.rsh);
      neg2 <= neg1;
    end
    if (ctl.en3) begin
      pq3  <= pq2;
      ql3  <= QL_W'(qe2) + QL_W'(rem >= W_W'(cst.dodd));
      neg3 <= neg2;
    end
  end

  // sum, apply sign, saturate to 32 bits
  assign qsum = (PQ_W+1)'(pq3) + (PQ_W+1)'(ql3);

  always_comb begin
    if (neg3) begin
      if (qsum > 33'h0_8000_0000) result = 32'sh8000_0000;
      else                        result = -signed'(qsum[31:0]);
    end else begin
      if (qsum > 33'h0_7fff_ffff) result = 32'sh7fff_ffff;
      else                        result = signed'(qsum[31:0]);
    end
  end

endmodule

/* rtl/imu_burst_read_decoder.sv */
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_stall     kind, data_byte, byte_index, last_byte, time_us
// out      out        out_valid/out_stall   accel_*, gyro_*, temperature_k, sensor_time,
//                                           start_time_us, finish_time_us, group_delay_us
//
// one input item per cycle while in_stall is low; the sequencer handles each
// item in its accept cycle; the last gyro byte launches a frame into a
// five-register scaling pipeline: stage 0, three lane stages, output register
// pipeline stages load when they are empty or their content moves on, so
// in_stall rises only when all stages hold frames and out_stall is high
// rst is synchronous: sequencer idle, pipeline empty, range registers zero
module imu_burst_read_decoder #(
  parameter int FRAC_BITS = ibrd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic [4:0]         byte_index,
  input  logic               last_byte,
  input  logic [31:0]        time_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z,
  output logic signed [31:0] gyro_x,
  output logic signed [31:0] gyro_y,
  output logic signed [31:0] gyro_z,
  output logic [30:0]        temperature_k,
  output logic [33:0]        sensor_time,
  output logic [31:0]        start_time_us,
  output logic [31:0]        finish_time_us,
  output logic [12:0]        group_delay_us
);
  import ibrd_pkg::*;

  localparam int LANES     = 6;
  localparam int ACC_LANES = 3;
  localparam int TW        = FRAC_BITS + 11;
  localparam longint unsigned TEMP_OFS =
    ((TEMP_OFS_CENTI << FRAC_BITS) + CENTI / 2) / CENTI;
  // lanes whose value is negated: accel x, y and gyro x, y
  localparam logic [LANES-1:0] FLIP = 6'b011011;

  localparam scale_t ACC_TAB [8] = '{
    acc_entry(FRAC_BITS, 1'b0, 2'd0), acc_entry(FRAC_BITS, 1'b0, 2'd1),
    acc_entry(FRAC_BITS, 1'b0, 2'd2), acc_entry(FRAC_BITS, 1'b0, 2'd3),
    acc_entry(FRAC_BITS, 1'b1, 2'd0), acc_entry(FRAC_BITS, 1'b1, 2'd1),
    acc_entry(FRAC_BITS, 1'b1, 2'd2), acc_entry(FRAC_BITS, 1'b1, 2'd3)
  };
  localparam scale_t GYR_TAB [8] = '{
    gyr_entry(FRAC_BITS, 3'd0), gyr_entry(FRAC_BITS, 3'd1),
    gyr_entry(FRAC_BITS, 3'd2), gyr_entry(FRAC_BITS, 3'd3),
    gyr_entry(FRAC_BITS, 3'd4), gyr_entry(FRAC_BITS, 3'd5),
    gyr_entry(FRAC_BITS, 3'd6), gyr_entry(FRAC_BITS, 3'd7)
  };

  // values that travel beside the scaling lanes
  typedef struct packed {
    logic [30:0] temp_k;
    logic [33:0] stime;
    logic [31:0] start;
    logic [31:0] finish;
    logic [12:0] gdel;
  } side_t;

  // magnitude of a 16-bit two's complement value
  function automatic logic [MAG_W-1:0] mag16(input logic [15:0] v);
    return v[15] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  // sign of the lane value after optional negation
  function automatic logic neg16(input logic [15:0] v, input logic flip);
    return flip ? (!v[15] && (|v)) : v[15];
  endfunction

  // range registers
  logic        base_sel;
  logic [1:0]  acc_code;
  logic [2:0]  gyr_code;
  logic [1:0]  rate_mode;

  // sequencer state and frame capture
  phase_t      phase, phase_next;
  logic [23:0] ticks, ticks_next;
  logic [31:0] axy, axy_next;
  logic [15:0] az, az_next;
  logic [47:0] gyr, gyr_next;
  logic [10:0] temp, temp_next;
  logic [31:0] stamp, stamp_next;
  logic        launch;
  logic        in_acc;

  // pipeline occupancy
  logic [4:0]  vld;
  logic [5:0]  rdy;
  lane_ctl_t   lane_ctl;

  // stage 0 frame
  logic [MAG_W-1:0] s0_mag [LANES];
  logic             s0_neg [LANES];
  logic [10:0]      s0_temp;
  logic [23:0]      s0_ticks;
  logic [31:0]      s0_start;
  logic [31:0]      s0_finish;
  logic [12:0]      s0_gdel;

  logic [15:0]      raw_next [LANES];
  logic [12:0]      gdel_sel;
  side_t            side1, side2, side3;
  side_t            side0_calc;
  logic signed [TW-1:0] t_sum;
  logic signed [47:0]   t_wide;

  scale_t           acc_cst, gyr_cst;
  logic signed [31:0] lane_res [LANES];
  logic signed [31:0] res_q    [LANES];

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;

  // range register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_sel  <= 1'b0;
      acc_code  <= 2'd0;
      gyr_code  <= 3'd0;
      rate_mode <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_SEL:  base_sel  <= cfg_data[0];
        CFG_ACC_RANGE: acc_code  <= cfg_data[1:0];
        CFG_GYR_RANGE: gyr_code  <= cfg_data[2:0];
        CFG_RATE_MODE: rate_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) phase <= PH_IDLE;
    else     phase <= phase_next;
  end

  // sequencer next state and byte capture
  always_comb begin
    phase_next = phase;
    ticks_next = ticks;
    axy_next   = axy;
    az_next    = az;
    gyr_next   = gyr;
    temp_next  = temp;
    stamp_next = stamp;
    launch     = 1'b0;
    if (in_acc) begin
      unique case (kind)
        KIND_START: begin
          ticks_next = '0;
          axy_next   = '0;
          az_next    = '0;
          gyr_next   = '0;
          temp_next  = '0;
          stamp_next = time_us;
          phase_next = PH_BURST;
        end
        KIND_ABORT: phase_next = PH_IDLE;
        KIND_BYTE: begin
          unique case (phase)
            PH_IDLE: ;
            PH_BURST: begin
              case (byte_index)
                POS_TICK0:    ticks_next[7:0]   = data_byte;
                POS_TICK1:    ticks_next[15:8]  = data_byte;
                POS_TICK2:    ticks_next[23:16] = data_byte;
                POS_AX_L:     axy_next[7:0]     = data_byte;
                POS_AX_H:     axy_next[15:8]    = data_byte;
                POS_AY_L:     axy_next[23:16]   = data_byte;
                POS_AY_H:     axy_next[31:24]   = data_byte;
                POS_TEMP_MSB: temp_next[10:3]   = data_byte;
                POS_TEMP_LSB: temp_next[2:0]    = data_byte[7:5];
                default: ;
              endcase
              if (last_byte) phase_next = PH_SYNC;
            end
            PH_SYNC: begin
              case (byte_index)
                POS_AZ_L: az_next[7:0]  = data_byte;
                POS_AZ_H: az_next[15:8] = data_byte;
                default: ;
              endcase
              if (last_byte) phase_next = PH_GYRO;
            end
            PH_GYRO: begin
              case (byte_index)
                POS_GX_L: gyr_next[7:0]   = data_byte;
                POS_GX_H: gyr_next[15:8]  = data_byte;
                POS_GY_L: gyr_next[23:16] = data_byte;
                POS_GY_H: gyr_next[31:24] = data_byte;
                POS_GZ_L: gyr_next[39:32] = data_byte;
                POS_GZ_H: gyr_next[47:40] = data_byte;
                default: ;
              endcase
              if (last_byte) begin
                phase_next = PH_IDLE;
                launch     = 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // frame capture registers
  always_ff @(posedge clk) begin
    ticks <= ticks_next;
    axy   <= axy_next;
    az    <= az_next;
    gyr   <= gyr_next;
    temp  <= temp_next;
    stamp <= stamp_next;
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[5] = !out_stall;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall     = !rdy[0];
  assign out_valid    = vld[4];
  assign lane_ctl.en1 = rdy[1];
  assign lane_ctl.en2 = rdy[2];
  assign lane_ctl.en3 = rdy[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= launch;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // raw lane values of the launching frame
  assign raw_next[0] = axy_next[15:0];
  assign raw_next[1] = axy_next[31:16];
  assign raw_next[2] = az_next;
  assign raw_next[3] = gyr_next[15:0];
  assign raw_next[4] = gyr_next[31:16];
  assign raw_next[5] = gyr_next[47:32];

  always_comb begin
    case (rate_mode)
      RATE_1000: gdel_sel = GD_1000;
      RATE_2000: gdel_sel = GD_2000;
      default:   gdel_sel = GD_400;
    endcase
  end

  // stage 0: frame as launched
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int g = 0; g < LANES; g++) begin
        s0_mag[g] <= mag16(raw_next[g]);
        s0_neg[g] <= neg16(raw_next[g], FLIP[g]);
      end
      s0_temp   <= temp_next;
      s0_ticks  <= ticks_next;
      s0_start  <= stamp_next;
      s0_finish <= time_us;
      s0_gdel   <= gdel_sel;
    end
  end

  // temperature in kelvin and sensor time
  assign t_sum  = (TW'(signed'(s0_temp)) <<< (FRAC_BITS - 3)) + TW'(TEMP_OFS);
  assign t_wide = 48'(t_sum);

  always_comb begin
    if (t_wide[47])           side0_calc.temp_k = '0;
    else if (|t_wide[46:31])  side0_calc.temp_k = TEMP_MAX;
    else                      side0_calc.temp_k = t_wide[30:0];
    side0_calc.stime  = 34'(s0_ticks) * 34'd625;
    side0_calc.start  = s0_start;
    side0_calc.finish = s0_finish;
    side0_calc.gdel   = s0_gdel;
  end

  // sideband follows the lanes
  always_ff @(posedge clk) begin
    if (rdy[1]) side1 <= side0_calc;
    if (rdy[2]) side2 <= side1;
    if (rdy[3]) side3 <= side2;
    if (rdy[4]) begin
      temperature_k  <= side3.temp_k;
      sensor_time    <= side3.stime;
      start_time_us  <= side3.start;
      finish_time_us <= side3.finish;
      group_delay_us <= side3.gdel;
      for (int g = 0; g < LANES; g++) begin
        res_q[g] <= lane_res[g];
      end
    end
  end

  // range constants for the lanes
  assign acc_cst = ACC_TAB[{base_sel, acc_code}];
  assign gyr_cst = GYR_TAB[gyr_code];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ibrd_scale u_scale (
      .clk    (clk),
      .ctl    (lane_ctl),
      .cst    ((g < ACC_LANES) ? acc_cst : gyr_cst),
      .mag    (s0_mag[g]),
      .neg    (s0_neg[g]),
      .result (lane_res[g])
    );
  end

  assign accel_x = res_q[0];
  assign accel_y = res_q[1];
  assign accel_z = res_q[2];
  assign gyro_x  = res_q[3];
  assign gyro_y  = res_q[4];
  assign gyro_z  = res_q[5];

  // input only held back when every stage holds a frame
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld))
    else $error("input stalled with a free pipeline stage");

  // the last gyro byte puts a frame in stage 0 and returns to idle
  a_launch: assert property (@(posedge clk) disable iff (rst)
    (in_acc && launch) |=> (vld[0] && phase == PH_IDLE))
    else $error("final gyro byte did not launch a frame");

  // a frame leaving stage 3 reaches the output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && rdy[4]) |=> out_valid)
    else $error("frame lost between last stage and output");

  // reset leaves nothing in flight
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && vld == '0 && phase == PH_IDLE))
    else $error("state left after reset");

endmodule

/* tb/imu_frame_check.sv */
module imu_frame_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic [4:0]         byte_index,
  input  logic               last_byte,
  input  logic [31:0]        time_us,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic [30:0]        temperature_k,
  input  logic [33:0]        sensor_time,
  input  logic [31:0]        start_time_us,
  input  logic [31:0]        finish_time_us,
  input  logic [12:0]        group_delay_us,
  input  logic               wrap_up,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ibrd_pkg::*;

  localparam int     FRAC       = FRAC_BITS_DEF;
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;
  // 296.15 K in fixed point, rounded to nearest
  localparam longint TEMP_OFS_Q = ((longint'(29615) << FRAC) + 50) / 100;

  // one decoded frame as the block should emit it
  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
    logic [30:0]        temp_k;
    logic [33:0]        ticks_16th;
    logic [31:0]        t_start;
    logic [31:0]        t_finish;
    logic [12:0]        delay;
  } imu_frame_t;

  // range settings
  logic       base_sel;
  logic [1:0] acc_code;
  logic [2:0] gyr_code;
  logic [1:0] rate;

  // sequencer and captured raw values
  phase_t      seq;
  logic [31:0] acc_xy;
  logic [15:0] acc_z;
  logic [47:0] gyr;
  logic [10:0] temp11;
  logic [23:0] ticks;
  logic [31:0] stamp;

  imu_frame_t frames_due[$];
  imu_frame_t want;
  bit         wrapped;

  initial begin
    fails   = 0;
    pending = 0;
    wrapped = 0;
  end

  task automatic flag(input string what);
    $display("%0t ns: %s", $time, what);
    fails++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got,
                           input logic [63:0] exp_val);
    if (got !== exp_val)
      flag($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  // round to nearest, ties away from zero
  function automatic longint near_div(input longint n, input longint unsigned d);
    longint unsigned m;
    longint unsigned q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] sat_q(input longint v);
    if (v > Q_MAX) return Q_MAX[31:0];
    if (v < Q_MIN) return Q_MIN[31:0];
    return v[31:0];
  endfunction

  // raw * 9.80665 * range_g / 2^17 in fixed point
  function automatic logic signed [31:0] accel_q(input longint raw);
    longint          num;
    longint unsigned den;
    int              s;
    s   = int'(acc_code) + FRAC;
    num = raw * 980665 * (base_sel ? 2 : 3);
    den = 100000;
    if (s >= 17) num = num * (longint'(1) << (s - 17));
    else den = den << (17 - s);
    return sat_q(near_div(num, den));
  endfunction

  // raw * 0.01745329252 / (8.192 * 2^(code+1)) in fixed point
  function automatic logic signed [31:0] gyro_q(input longint raw);
    longint          num;
    longint unsigned den;
    int              e;
    e   = FRAC - 14 - int'(gyr_code);
    num = raw * 1745329252;
    den = 100000000;
    if (e >= 0) num = num * (longint'(1) << e);
    else den = den << (-e);
    return sat_q(near_div(num, den));
  endfunction

  task automatic clear_raw();
    acc_xy = '0;
    acc_z  = '0;
    gyr    = '0;
    temp11 = '0;
    ticks  = '0;
  endtask

  // advance the sequencer by one accepted item
  task automatic take_item(input logic [1:0] k, input logic [7:0] b,
                           input logic [4:0] idx, input logic lst,
                           input logic [31:0] t);
    imu_frame_t f;
    longint     tk;
    if (k == KIND_START) begin
      clear_raw();
      stamp = t;
      seq   = PH_BURST;
    end else if (k == KIND_ABORT) begin
      seq = PH_IDLE;
    end else if (k == KIND_BYTE && seq != PH_IDLE) begin
      case (seq)
        PH_BURST: begin
          if (idx >= POS_TICK0 && idx <= POS_TICK2) ticks[8*(idx-POS_TICK0) +: 8] = b;
          else if (idx >= POS_AX_L && idx <= POS_AY_H) acc_xy[8*(idx-POS_AX_L) +: 8] = b;
          else if (idx == POS_TEMP_MSB) temp11[10:3] = b;
          else if (idx == POS_TEMP_LSB) temp11[2:0] = b[7:5];
          if (lst) seq = PH_SYNC;
        end
        PH_SYNC: begin
          if (idx == POS_AZ_L || idx == POS_AZ_H) acc_z[8*(idx-POS_AZ_L) +: 8] = b;
          if (lst) seq = PH_GYRO;
        end
        default: begin
          if (idx >= POS_GX_L && idx <= POS_GZ_H) gyr[8*(idx-POS_GX_L) +: 8] = b;
          if (lst) begin
            seq  = PH_IDLE;
            f.ax = accel_q(-longint'($signed(acc_xy[15:0])));
            f.ay = accel_q(-longint'($signed(acc_xy[31:16])));
            f.az = accel_q(longint'($signed(acc_z)));
            f.gx = gyro_q(-longint'($signed(gyr[15:0])));
            f.gy = gyro_q(-longint'($signed(gyr[31:16])));
            f.gz = gyro_q(longint'($signed(gyr[47:32])));
            // kelvin: signed 11-bit raw / 8 plus offset, clamped
            tk = longint'($signed(temp11)) * (longint'(1) << (FRAC - 3)) + TEMP_OFS_Q;
            if (tk > Q_MAX) tk = Q_MAX;
            if (tk < 0) tk = 0;
            f.temp_k     = tk[30:0];
            f.ticks_16th = 34'(longint'(ticks) * 625);
            f.t_start    = stamp;
            f.t_finish   = t;
            f.delay      = (rate == RATE_1000) ? GD_1000 :
                           (rate == RATE_2000) ? GD_2000 : GD_400;
            frames_due.push_back(f);
          end
        end
      endcase
    end
  endtask

  // watch all three channels at the sampling edge
  always @(posedge clk) begin
    if (rst) begin
      base_sel = 1'b0;
      acc_code = '0;
      gyr_code = '0;
      rate     = '0;
      seq      = PH_IDLE;
      stamp    = '0;
      clear_raw();
      frames_due.delete();
    end else begin
      // range register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_SEL:  base_sel = cfg_data[0];
          CFG_ACC_RANGE: acc_code = cfg_data[1:0];
          CFG_GYR_RANGE: gyr_code = cfg_data[2:0];
          CFG_RATE_MODE: rate     = cfg_data[1:0];
          default: ;
        endcase
      end
      // emitted frames against the oldest expected one
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          flag("frame emitted with none expected");
        end else begin
          want = frames_due.pop_front();
          cmp_field("accel_x", accel_x, want.ax);
          cmp_field("accel_y", accel_y, want.ay);
          cmp_field("accel_z", accel_z, want.az);
          cmp_field("gyro_x", gyro_x, want.gx);
          cmp_field("gyro_y", gyro_y, want.gy);
          cmp_field("gyro_z", gyro_z, want.gz);
          cmp_field("temperature_k", temperature_k, want.temp_k);
          cmp_field("sensor_time", sensor_time, want.ticks_16th);
          cmp_field("start_time_us", start_time_us, want.t_start);
          cmp_field("finish_time_us", finish_time_us, want.t_finish);
          cmp_field("group_delay_us", group_delay_us, want.delay);
        end
      end
      if (in_valid && !in_stall)
        take_item(kind, data_byte, byte_index, last_byte, time_us);
      // frames still owed at the end
      if (wrap_up && !wrapped) begin
        wrapped = 1;
        if (frames_due.size() != 0)
          flag($sformatf("%0d expected frames never emitted", frames_due.size()));
      end
    end
    pending = frames_due.size();
  end

endmodule

/* tb/imu_burst_read_decoder_test.sv */
module imu_burst_read_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ibrd_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {
    FR_CLEAN,
    FR_RESTART,
    FR_ABORT
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  kind       = '0;
  logic [7:0]  data_byte  = '0;
  logic [4:0]  byte_index = '0;
  logic        last_byte  = 1'b0;
  logic [31:0] time_us    = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;

  logic signed [31:0] accel_x, accel_y, accel_z;
  logic signed [31:0] gyro_x, gyro_y, gyro_z;
  logic [30:0]        temperature_k;
  logic [33:0]        sensor_time;
  logic [31:0]        start_time_us, finish_time_us;
  logic [12:0]        group_delay_us;

  logic wrap_up = 1'b0;
  int   fails;
  int   pending;

  // stimulus bookkeeping
  bit calm       = 0;
  bit noise_on   = 0;
  int useful     = 0;
  int frames_out = 0;
  int stall_hold = 0;
  int stall_roll;

  imu_burst_read_decoder u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .byte_index(byte_index),
    .last_byte(last_byte), .time_us(time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .temperature_k(temperature_k), .sensor_time(sensor_time),
    .start_time_us(start_time_us), .finish_time_us(finish_time_us),
    .group_delay_us(group_delay_us)
  );

  imu_frame_check u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .data_byte(data_byte), .byte_index(byte_index),
    .last_byte(last_byte), .time_us(time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
    .temperature_k(temperature_k), .sensor_time(sensor_time),
    .start_time_us(start_time_us), .finish_time_us(finish_time_us),
    .group_delay_us(group_delay_us),
    .wrap_up(wrap_up), .fails(fails), .pending(pending)
  );

  always #4 clk = ~clk;

  // hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stalls: mostly short runs, a few long ones
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      out_stall <= (stall_roll < 35);
      stall_hold = (stall_roll < 5) ? $urandom_range(12, 50) : $urandom_range(0, 4);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // bytes lean toward sign and range extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // present one item and hold it until accepted
  task automatic send_item(input logic [1:0] k, input logic [7:0] b,
                           input logic [4:0] idx, input logic lst,
                           input logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    byte_index <= idx;
    last_byte  <= lst;
    time_us    <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!noise_on && k != KIND_SPARE) useful++;
  endtask

  // drop valid, wait for every expected frame, then some quiet cycles
  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry random junk
  task automatic set_ranges(input logic b, input logic [1:0] a, input logic [2:0] g,
                            input logic [1:0] r);
    write_reg(CFG_BASE_SEL, {7'($urandom), b});
    write_reg(CFG_ACC_RANGE, {6'($urandom), a});
    write_reg(CFG_GYR_RANGE, {5'($urandom), g});
    write_reg(CFG_RATE_MODE, {6'($urandom), r});
  endtask

  // one transfer by position; sometimes ends on an unused position
  task automatic send_transfer(input int lo, input int hi);
    bit tail;
    int i;
    tail = ($urandom_range(0, 6) == 0);
    for (i = lo; i <= hi; i++)
      send_item(KIND_BYTE, rand_byte(), 5'(i), !tail && i == hi, rand_time());
    if (tail)
      send_item(KIND_BYTE, rand_byte(), 5'($urandom_range(20, 31)), 1'b1, rand_time());
  endtask

  task automatic send_start();
    send_item(KIND_START, rand_byte(), 5'($urandom), 1'($urandom), rand_time());
  endtask

  // full sequence: burst, sync read, gyro burst
  task automatic run_frame(input frame_kind_t fk);
    bit full;
    int cut;
    full = ($urandom_range(0, 3) == 0);
    send_start();
    if (fk == FR_ABORT) begin
      cut = $urandom_range(0, 2);
      if (cut >= 1) send_transfer(full ? 0 : 8, 19);
      if (cut >= 2) send_transfer(full ? 0 : 2, 3);
      send_item(KIND_ABORT, rand_byte(), 5'($urandom), 1'($urandom), rand_time());
    end else begin
      send_transfer(full ? 0 : 8, 19);
      if (fk == FR_RESTART) begin
        send_start();
        send_transfer(full ? 0 : 8, 19);
      end
      send_transfer(full ? 0 : 2, 3);
      send_transfer(full ? 0 : 1, 6);
      frames_out++;
    end
  endtask

  // unstructured items of any kind and position
  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(3, 12);
    noise_on = 1;
    for (i = 0; i < n; i++)
      send_item(2'($urandom_range(0, 3)), rand_byte(), 5'($urandom_range(0, 31)),
                1'($urandom_range(0, 1)), rand_time());
    noise_on = 0;
  endtask

  initial begin
    int p;
    int n;
    int r;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // idle handling: stray byte, unused kind, abort with nothing running
    send_item(KIND_BYTE, 8'hA5, POS_TICK0, 1'b1, 32'h0);
    send_item(KIND_SPARE, 8'hFF, 5'd31, 1'b1, 32'hFFFF_FFFF);
    send_item(KIND_ABORT, 8'h00, 5'd0, 1'b0, 32'h0);
    // abort mid-burst
    send_item(KIND_START, 8'h00, 5'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(KIND_BYTE, 8'h5A, POS_TICK0, 1'b0, 32'h1);
    send_item(KIND_ABORT, 8'h00, 5'd0, 1'b0, 32'h0);
    // restart while busy must clear the accel x low byte
    send_item(KIND_START, 8'h00, 5'd0, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h33, POS_AX_L, 1'b0, 32'h2);
    send_item(KIND_START, 8'hFF, 5'd31, 1'b1, 32'hFFFF_FFFF);
    // extreme raw values: full tick count, words at both sign extremes, coldest temperature
    send_item(KIND_BYTE, 8'hFF, POS_TICK0, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'hFF, POS_TICK1, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'hFF, POS_TICK2, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h80, POS_AX_H, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'hFF, POS_AY_L, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h7F, POS_AY_H, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h80, POS_TEMP_MSB, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h00, POS_TEMP_LSB, 1'b1, 32'h0);
    send_item(KIND_BYTE, 8'h00, POS_AZ_L, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h80, POS_AZ_H, 1'b1, 32'h0);
    send_item(KIND_BYTE, 8'h00, POS_GX_L, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h80, POS_GX_H, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h01, POS_GY_L, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h80, POS_GY_H, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'hFF, POS_GZ_L, 1'b0, 32'h0);
    send_item(KIND_BYTE, 8'h7F, POS_GZ_H, 1'b1, 32'h0);

    // random frames, ranges changed between phases while the block is quiet
    for (p = 0; p < 10 || useful < 800 || frames_out < 20; p++) begin
      calm = 0;
      settle(8);
      case (p)
        0: set_ranges(1'b0, 2'd0, 3'd0, 2'd0);
        1: set_ranges(1'b1, 2'd3, 3'd7, 2'd3);
        default: set_ranges(1'($urandom), 2'($urandom), 3'(p - 2), 2'($urandom));
      endcase
      calm = (p % 4 == 3);
      for (n = 0; n < 4; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) send_noise();
        else if (r < 65) run_frame(FR_CLEAN);
        else if (r < 80) run_frame(FR_RESTART);
        else run_frame(FR_ABORT);
        // in phase 2 the sender holds off until the pipeline has drained
        if (p == 2) settle(0);
      end
    end

    calm = 0;
    settle(20);
    wrap_up <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* imu_burst_read_decoder.f */
rtl/ibrd_pkg.sv
rtl/ibrd_scale.sv
rtl/imu_burst_read_decoder.sv
tb/imu_frame_check.sv
tb/imu_burst_read_decoder_test.sv
